FILE: hdl/urt_pkg.sv
// Shared constants, register indexes and controller/datapath handshake types
// for the ultrasonic range tone controller. No dependencies.
package urt_pkg;

  localparam int TimerWidth = 16;
  localparam int ToneWidth  = 8;
  localparam int StartDelay = 16;

  localparam int WidthW   = 16;
  localparam int PeriodW  = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int DivW     = WidthW + PeriodW;
  localparam int DivCntW  = $clog2(DivW);

  localparam logic [CfgIdxW-1:0] RegTrigHigh  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTrigLow   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNearLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFarLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPerNear   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPerFar    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPrescale  = 3'd6;

  localparam logic [15:0] TrigHighRst  = 16'd20;
  localparam logic [15:0] TrigLowRst   = 16'd38000;
  localparam logic [15:0] NearLimitRst = 16'd475;
  localparam logic [15:0] FarLimitRst  = 16'd5500;
  localparam logic [7:0]  PerNearRst   = 8'd58;
  localparam logic [7:0]  PerFarRst    = 8'd118;
  localparam logic [7:0]  PrescaleRst  = 8'd8;

  typedef struct packed {
    logic load_in;
    logic range_en;
    logic mul_en;
    logic div_step;
    logic map_en;
    logic tone_en;
  } urt_cmd_t;

  typedef struct packed {
    logic meas_done;
    logic div_last;
  } urt_status_t;

endpackage

FILE: hdl/urt_if.sv
// Stream channels of the ultrasonic range tone controller: tick input and
// result output, each with valid/ready. Depends on urt_pkg.
interface urt_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface urt_out_if
  import urt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               trigger_level;
  logic               tone_level;
  logic [WidthW-1:0]  echo_width;
  logic               width_valid;
  logic [PeriodW-1:0] tone_period;

  modport source (output valid, output trigger_level, output tone_level,
                  output echo_width, output width_valid, output tone_period,
                  input ready);
  modport sink (input valid, input trigger_level, input tone_level,
                input echo_width, input width_valid, input tone_period,
                output ready);
endinterface

FILE: hdl/urt_ctrl.sv
// Sequencer of the ultrasonic range tone controller: steps one tick through
// ranging, width mapping (multiply, serial divide) and tone. Depends on urt_pkg.
module urt_ctrl
  import urt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  urt_status_t status_i,
  output urt_cmd_t    cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRange = 3'd1;
  localparam logic [2:0] SMul   = 3'd2;
  localparam logic [2:0] SDiv   = 3'd3;
  localparam logic [2:0] SMap   = 3'd4;
  localparam logic [2:0] STone  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = SRange;
        end
      end
      SRange: begin
        cmd_o.range_en = 1'b1;
        state_d        = status_i.meas_done ? SMul : STone;
      end
      SMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = SMap;
      end
      SMap: begin
        cmd_o.map_en = 1'b1;
        state_d      = STone;
      end
      STone: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd_o.tone_en = 1'b1;
          state_d       = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.tone_en) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/urt_datapath.sv
// Datapath of the ultrasonic range tone controller: configuration registers,
// ranging counters, width-to-period mapping with a restoring divider, tone
// generator and output register. Depends on urt_pkg.
module urt_datapath
  import urt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                echo_level_i,
  input  urt_cmd_t            cmd_i,
  output urt_status_t         status_o,
  output logic                trigger_level_o,
  output logic                tone_level_o,
  output logic [WidthW-1:0]   echo_width_o,
  output logic                width_valid_o,
  output logic [PeriodW-1:0]  tone_period_o
);

  localparam logic [1:0] PhStart   = 2'd0;
  localparam logic [1:0] PhHigh    = 2'd1;
  localparam logic [1:0] PhWait    = 2'd2;
  localparam logic [1:0] PhMeasure = 2'd3;

  localparam int CmpW = TimerWidth + 1;

  // configuration
  logic [15:0] high_q, low_q, near_q, far_q;
  logic [7:0]  pnear_q, pfar_q, pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q  <= TrigHighRst;
      low_q   <= TrigLowRst;
      near_q  <= NearLimitRst;
      far_q   <= FarLimitRst;
      pnear_q <= PerNearRst;
      pfar_q  <= PerFarRst;
      pre_q   <= PrescaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTrigHigh:  high_q  <= cfg_wdata_i;
        RegTrigLow:   low_q   <= cfg_wdata_i;
        RegNearLimit: near_q  <= cfg_wdata_i;
        RegFarLimit:  far_q   <= cfg_wdata_i;
        RegPerNear:   pnear_q <= cfg_wdata_i[7:0];
        RegPerFar:    pfar_q  <= cfg_wdata_i[7:0];
        RegPrescale:  pre_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ranging state
  logic [1:0]            phase_q, phase_d;
  logic [TimerWidth-1:0] tick_q, tick_d, tick_inc;
  logic                  echo_q, echo_prev_q, echo_prev_d;
  logic [WidthW-1:0]     width_q, width_d, width_sat;
  logic                  wvalid_q, wvalid_d;
  logic                  rise;

  // mapping operands
  logic [WidthW-1:0]  off_q, off_d, span_q, span_d, w_clamp;
  logic [PeriodW-1:0] diff_q, diff_d;
  logic               dec_q, dec_d, nomap_q, nomap_d;

  // divider
  logic [DivW-1:0]    quo_q, quo_d;
  logic [WidthW-1:0]  rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [WidthW:0]    rem_sh;
  logic [WidthW+1:0]  rem_sub;

  // tone
  logic [ToneWidth-1:0] cmp_q, cmp_d, tcnt_q, tcnt_d;
  logic [7:0]           pres_q, pres_d, pres_inc;
  logic                 pin_q, pin_d;
  logic [PeriodW-1:0]   quo_lo;

  assign tick_inc  = (tick_q == '1) ? tick_q : tick_q + 1'b1;
  assign rise      = echo_q && !echo_prev_q;
  assign width_sat = (CmpW'(tick_q) > CmpW'(17'h0FFFF)) ? 16'hFFFF : 16'(tick_q);
  assign w_clamp   = (width_sat < near_q) ? near_q :
                     (width_sat > far_q)  ? far_q  : width_sat;

  assign status_o.meas_done = (phase_q == PhMeasure) && !echo_q;
  assign status_o.div_last  = (cnt_q == DivCntW'(DivW - 1));

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    echo_prev_d = echo_prev_q;
    width_d     = width_q;
    wvalid_d    = wvalid_q;
    off_d       = off_q;
    span_d      = span_q;
    diff_d      = diff_q;
    dec_d       = dec_q;
    nomap_d     = nomap_q;
    if (cmd_i.load_in) wvalid_d = 1'b0;
    if (cmd_i.range_en) begin
      echo_prev_d = echo_q;
      unique case (phase_q)
        PhStart: begin
          tick_d = tick_inc;
          if (CmpW'(tick_inc) >= CmpW'(StartDelay)) begin
            phase_d = PhHigh;
            tick_d  = '0;
          end
        end
        PhHigh: begin
          tick_d = tick_inc;
          if (CmpW'(tick_inc) >= CmpW'(high_q)) begin
            phase_d = PhWait;
            tick_d  = '0;
          end
        end
        PhWait: begin
          tick_d = tick_inc;
          if (rise) begin
            phase_d = PhMeasure;
            tick_d  = TimerWidth'(1);
          end else if (CmpW'(tick_inc) >= CmpW'(low_q)) begin
            phase_d = PhHigh;
            tick_d  = '0;
          end
        end
        PhMeasure: begin
          if (!echo_q) begin
            width_d  = width_sat;
            wvalid_d = 1'b1;
            phase_d  = PhStart;
            tick_d   = '0;
            off_d    = w_clamp - near_q;
            span_d   = far_q - near_q;
            dec_d    = pfar_q < pnear_q;
            diff_d   = (pfar_q < pnear_q) ? pnear_q - pfar_q : pfar_q - pnear_q;
            nomap_d  = far_q <= near_q;
          end else begin
            tick_d = tick_inc;
            // drop an echo that outlasts the timeout
            if (CmpW'(tick_inc) >= CmpW'(low_q)) begin
              phase_d = PhHigh;
              tick_d  = '0;
            end
          end
        end
        default: phase_d = PhStart;
      endcase
    end
  end

  // restoring divide of off * diff by span, one quotient bit per step
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, span_q};
  assign quo_lo  = quo_q[PeriodW-1:0];

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.mul_en) begin
      quo_d = DivW'(off_q) * DivW'(diff_q);
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      cnt_d = cnt_q + 1'b1;
      if (!rem_sub[WidthW+1]) begin
        rem_d = rem_sub[WidthW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WidthW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign pres_inc = (pres_q == 8'hFF) ? pres_q : pres_q + 8'd1;

  always_comb begin
    cmp_d  = cmp_q;
    tcnt_d = tcnt_q;
    pres_d = pres_q;
    pin_d  = pin_q;
    if (cmd_i.map_en) begin
      if (nomap_q)    cmp_d = ToneWidth'(pnear_q);
      else if (dec_q) cmp_d = ToneWidth'(pnear_q - quo_lo);
      else            cmp_d = ToneWidth'(pnear_q + quo_lo);
    end
    if (cmd_i.tone_en) begin
      pres_d = pres_inc;
      if (pres_inc >= pre_q) begin
        pres_d = '0;
        if (tcnt_q >= cmp_q) begin
          tcnt_d = '0;
          pin_d  = !pin_q;
        end else begin
          tcnt_d = tcnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      tick_q      <= '0;
      echo_prev_q <= 1'b0;
      width_q     <= '0;
      wvalid_q    <= 1'b0;
      cmp_q       <= ToneWidth'(PerFarRst);
      tcnt_q      <= '0;
      pres_q      <= '0;
      pin_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      echo_prev_q <= echo_prev_d;
      width_q     <= width_d;
      wvalid_q    <= wvalid_d;
      cmp_q       <= cmp_d;
      tcnt_q      <= tcnt_d;
      pres_q      <= pres_d;
      pin_q       <= pin_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) echo_q <= echo_level_i;
    off_q   <= off_d;
    span_q  <= span_d;
    diff_q  <= diff_d;
    dec_q   <= dec_d;
    nomap_q <= nomap_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    if (cmd_i.tone_en) begin
      trigger_level_o <= (phase_q == PhHigh);
      tone_level_o    <= pin_d;
      echo_width_o    <= width_q;
      width_valid_o   <= wvalid_q;
      tone_period_o   <= cmp_d[PeriodW-1:0];
    end
  end

endmodule

FILE: hdl/ultrasonic_range_tone_controller.sv
// Top level of the ultrasonic range tone controller: sequencer plus datapath.
// Depends on urt_pkg, urt_if, urt_ctrl and urt_datapath.
//
// Usage:
//  - in_ch carries one timer tick per transfer with the sampled echo level.
//  - out_ch returns exactly one result per tick: trigger and tone pin levels,
//    the last echo width, a flag on the tick a width was measured, and the
//    tone compare value in use.
//  - Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//    no tick is in flight; an unused index is ignored.
// Timing:
//  - An ordinary tick goes from idle through ranging to the tone step, which
//    writes its result to the output register; the next tick is taken in idle.
//  - The tick that ends an echo also passes through the product, 24 serial
//    divide steps and the map step before its tone step.
//  - A new tick is taken once the previous one reaches the output register,
//    so a result may wait on out_ch while the next tick is being worked on.
//  - When out_ch stalls, the block holds its result and the following tick
//    waits in its last step until the output register is free.
// Reset: asynchronous, active low; registers return to their defaults, the
// ranging sequence restarts with the start delay and the tone pin state is low.
module ultrasonic_range_tone_controller
  import urt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  urt_in_if.sink              in_ch,
  urt_out_if.source           out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  urt_cmd_t    cmd;
  urt_status_t status;
  logic        in_ready;
  logic        out_valid;

  urt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  urt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .echo_level_i    (in_ch.echo_level),
    .cmd_i           (cmd),
    .status_o        (status),
    .trigger_level_o (out_ch.trigger_level),
    .tone_level_o    (out_ch.tone_level),
    .echo_width_o    (out_ch.echo_width),
    .width_valid_o   (out_ch.width_valid),
    .tone_period_o   (out_ch.tone_period)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // a tick in work blocks the next transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in work");

  // never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tone_en |-> (!out_valid || out_ch.ready))
    else $error("pending result overwritten");

  // the mapped period is written only right after the last divide step
  a_map_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.map_en |-> $past(cmd.div_step) && $past(status.div_last))
    else $error("tone period mapped before divide finished");

endmodule
